// File: rtl/core/plst_pkg.sv
// Package for the positional list store: request kinds, status codes and
// the operation struct passed from the decode to the slot store. No dependencies.
package plst_pkg;

	typedef enum logic [2:0] {
		KIND_INS_FRONT = 3'd0,
		KIND_INS_BACK  = 3'd1,
		KIND_INS_AT    = 3'd2,
		KIND_DEL_FRONT = 3'd3,
		KIND_DEL_BACK  = 3'd4,
		KIND_DEL_AT    = 3'd5,
		KIND_READ_AT   = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	localparam int unsigned KIND_W  = 3;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned COUNT_W = 5;

	typedef struct packed {
		logic ins;
		logic del;
	} store_op_t;

endpackage

// File: rtl/core/plst_req_if.sv
// Request channel of the positional list store: valid/ready plus one item.
// Depends on plst_pkg for field widths.
interface plst_req_if;
	logic                                    valid;
	logic                                    ready;
	logic [plst_pkg::KIND_W-1:0]             kind;
	logic signed [plst_pkg::VALUE_W-1:0]     value;
	logic [plst_pkg::POS_W-1:0]              position;

	modport source (output valid, kind, value, position, input ready);
	modport sink   (input valid, kind, value, position, output ready);
endinterface

// File: rtl/core/plst_rsp_if.sv
// Result channel of the positional list store: valid/ready plus one item.
// Depends on plst_pkg for field widths.
interface plst_rsp_if;
	logic                                    valid;
	logic                                    ready;
	logic [plst_pkg::STAT_W-1:0]             status;
	logic [plst_pkg::COUNT_W-1:0]            element_count;
	logic signed [plst_pkg::VALUE_W-1:0]     read_value;

	modport source (output valid, status, element_count, read_value, input ready);
	modport sink   (input valid, status, element_count, read_value, output ready);
endinterface

// File: rtl/core/positional_list_store_top.sv
// Top level of the positional list store: input register, decode, slot store
// and result register. Depends on plst_pkg, plst_req_if, plst_rsp_if, plst_store.

// Ordered list of up to CAPACITY signed 32-bit values with insert and delete
// at front, back or a 1-based position, and read at a 1-based position. One
// item is taken every cycle under no backpressure; its result goes through the
// input register and then the result register, where it is held until taken.
// On insert or delete the slots from the index upward move by one place in
// parallel, and a read selects one slot through a CAPACITY-way multiplexer,
// so the decode-and-shift stage between the two registers sets the rate. A
// rejected item leaves the list untouched and reports its status;
// element_count is the count after the item, low 5 bits.
module positional_list_store_top #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	plst_req_if.sink     req,
	plst_rsp_if.source   rsp
);
	import plst_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned IW = $clog2(CAPACITY);
	localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic                      valid_s1;
	logic [KIND_W-1:0]         kind_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic [POS_W-1:0]          pos_s1;

	logic                      out_valid_q;
	status_t                   status_q;
	logic [COUNT_W-1:0]        count_q;
	logic signed [VALUE_W-1:0] rdval_q;

	logic                      advance;
	kind_t                     kind_c;
	store_op_t                 op_c;
	store_op_t                 op_go;
	logic [CW-1:0]             idx_c;
	status_t                   status_c;
	logic                      rd_ok_c;
	logic [CW-1:0]             fill;
	logic [XW-1:0]             fill_x;
	logic [XW-1:0]             pos_x;
	logic                      full_c;
	logic                      empty_c;
	logic [IW-1:0]             rd_idx;
	logic signed [VALUE_W-1:0] rd_data;
	logic [CW-1:0]             cnt_nxt;
	logic [CW+COUNT_W-1:0]     cnt_w;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_s1  <= req.kind;
			value_s1 <= req.value;
			pos_s1   <= req.position;
		end
	end

	assign kind_c  = kind_t'(kind_s1);
	assign fill_x  = XW'(fill);
	assign pos_x   = XW'(pos_s1);
	assign full_c  = (fill == CW'(CAPACITY));
	assign empty_c = (fill == '0);
	assign rd_idx  = IW'(pos_x - XW'(1));

	always_comb begin
		op_c     = '0;
		idx_c    = '0;
		status_c = ST_OK;
		rd_ok_c  = 1'b0;
		unique case (kind_c)
			KIND_INS_FRONT: begin
				if (full_c) status_c = ST_FULL;
				else op_c.ins = 1'b1;
			end
			KIND_INS_BACK: begin
				if (full_c) begin
					status_c = ST_FULL;
				end else begin
					op_c.ins = 1'b1;
					idx_c    = fill;
				end
			end
			KIND_INS_AT: begin
				if (pos_x == '0 || pos_x > fill_x + XW'(1)) begin
					status_c = ST_BADPOS;
				end else if (full_c) begin
					status_c = ST_FULL;
				end else begin
					op_c.ins = 1'b1;
					idx_c    = CW'(pos_x - XW'(1));
				end
			end
			KIND_DEL_FRONT: begin
				if (empty_c) status_c = ST_EMPTY;
				else op_c.del = 1'b1;
			end
			KIND_DEL_BACK: begin
				if (empty_c) begin
					status_c = ST_EMPTY;
				end else begin
					op_c.del = 1'b1;
					idx_c    = fill - CW'(1);
				end
			end
			KIND_DEL_AT: begin
				if (empty_c) begin
					status_c = ST_EMPTY;
				end else if (pos_x == '0 || pos_x > fill_x) begin
					status_c = ST_BADPOS;
				end else begin
					op_c.del = 1'b1;
					idx_c    = CW'(pos_x - XW'(1));
				end
			end
			KIND_READ_AT: begin
				if (pos_x == '0 || pos_x > fill_x) status_c = ST_BADPOS;
				else rd_ok_c = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign op_go.ins = op_c.ins && advance;
	assign op_go.del = op_c.del && advance;

	plst_store #(
		.CAPACITY (CAPACITY),
		.CW       (CW),
		.IW       (IW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op_go),
		.idx     (idx_c),
		.value   (value_s1),
		.rd_idx  (rd_idx),
		.rd_data (rd_data),
		.fill    (fill)
	);

	always_comb begin
		priority if (op_c.ins) begin
			cnt_nxt = fill + CW'(1);
		end else if (op_c.del) begin
			cnt_nxt = fill - CW'(1);
		end else begin
			cnt_nxt = fill;
		end
	end

	assign cnt_w = (CW + COUNT_W)'(cnt_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_c;
			count_q  <= cnt_w[COUNT_W-1:0];
			rdval_q  <= rd_ok_c ? rd_data : '0;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.element_count = count_q;
	assign rsp.read_value    = rdval_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		op_go.ins |=> fill == CW'($past(fill) + CW'(1)))
		else $error("insert did not raise the count by one");

	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && status_c != ST_OK) |=> $stable(fill))
		else $error("rejected item changed the list");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> rdval_q == '0)
		else $error("read value not zero on a failed item");

endmodule

// File: rtl/core/plst_store.sv
// Slot row and element count of the positional list store. Every slot from the
// index upward shifts by one place in parallel on insert or delete. Depends on plst_pkg.
module plst_store #(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned CW       = $clog2(CAPACITY + 1),
	parameter int unsigned IW       = $clog2(CAPACITY)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  plst_pkg::store_op_t             op,
	input  logic [CW-1:0]                   idx,
	input  logic signed [plst_pkg::VALUE_W-1:0] value,
	input  logic [IW-1:0]                   rd_idx,
	output logic signed [plst_pkg::VALUE_W-1:0] rd_data,
	output logic [CW-1:0]                   fill
);
	import plst_pkg::*;

	logic signed [VALUE_W-1:0] slots_q [CAPACITY];
	logic [CW-1:0]             fill_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
		logic [CW-1:0] pos_c;
		assign pos_c = CW'(i);

		always_ff @(posedge clk) begin
			if (op.ins && pos_c >= idx) begin
				if (pos_c == idx) begin
					slots_q[i] <= value;
				end else begin
					slots_q[i] <= slots_q[(i > 0) ? i - 1 : 0];
				end
			end else if (op.del && pos_c >= idx && i < CAPACITY - 1) begin
				slots_q[i] <= slots_q[(i < CAPACITY - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (op.ins) begin
			fill_q <= fill_q + CW'(1);
		end else if (op.del) begin
			fill_q <= fill_q - CW'(1);
		end
	end

	assign rd_data = slots_q[rd_idx];
	assign fill    = fill_q;

endmodule
